>>> rtl/wfrm_pkg.sv
// ----------------------------------------------------------------------------
// wfrm_pkg: shared types and constants of the windowed frame rate meter
// Holds the controller state type, the command and status structs between
// controller and datapath, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package wfrm_pkg;

  localparam int WFRM_DEPTH_DEF = 16;

  localparam int TS_W    = 64;
  localparam int RATE_W  = 32;
  localparam int TOTAL_W = 48;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 160;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAX_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART_LIMIT = 1'b1;

  localparam logic [CFG_W-1:0] MIN_MAX_DELAY_RST = 16'd16;
  localparam logic [CFG_W-1:0] RESTART_LIMIT_RST = 16'd1000;

  // One second in microseconds scaled by 2^8 for the Q24.8 result
  localparam longint unsigned RATE_SCALE = 64'd256000000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_WSUM,
    S_DINIT,
    S_DIV,
    S_STATS
  } state_t;

  typedef struct packed {
    logic load;      // latch the input word
    logic delta;     // form the clamped delta
    logic wsum;      // update window sum and ring
    logic div_init;  // start the divider
    logic div_step;  // one divider bit
    logic stats;     // update statistics and result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/windowed_frame_rate_meter.sv
// ----------------------------------------------------------------------------
// windowed_frame_rate_meter: moving-average frame rate with min, max and sum
// Takes one timestamp per frame and returns the windowed rate and statistics.
// ----------------------------------------------------------------------------
// Each frame passes through intake, delta, window update, divider start, the
// bit-serial restoring divider and statistics before the next one is taken.
// The divider makes one quotient bit per cycle over NUM_W bits, where NUM_W
// is the bit length of WINDOW_DEPTH * 256000000 (32 at the default depth of
// 16). A result waits in an output register, and the next frame is taken
// while it waits. That frame holds in its statistics step until the earlier
// result is read. The delta ring lives in a RAM. Entries not yet written
// since reset read as zero through a fill flag, so no clearing pass runs
// after reset.
`default_nettype none

module windowed_frame_rate_meter
  import wfrm_pkg::*;
#(
  parameter int WINDOW_DEPTH = WFRM_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [63:0] timestamp_us
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [31:0] frame_rate, [63:32] min_rate, [95:64] max_rate,
  // [143:96] rate_sum, [159:144] frames_counted
  output logic      [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  wfrm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  wfrm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_tdata)
  );

`ifndef SYNTHESIS
  // busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // a result appears only from a statistics update
  a_valid_from_stats: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.stats))
    else $error("result valid without statistics update");

  a_stats_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stats |=> out_tvalid)
    else $error("statistics update lost its result");

  // never more than one controller action at once
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

>>> rtl/wfrm_ram.sv
// ----------------------------------------------------------------------------
// wfrm_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wfrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/wfrm_dp.sv
// ----------------------------------------------------------------------------
// wfrm_dp: datapath of the windowed frame rate meter
// Delta ring, window sum, bit-serial divider, statistics and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wfrm_dp
  import wfrm_pkg::*;
#(
  parameter int WINDOW_DEPTH = WFRM_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 status,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  output logic      [OUT_DATA_W-1:0] out_data
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = RATE_W + AW;
  localparam longint unsigned RATE_NUM = longint'(WINDOW_DEPTH) * RATE_SCALE;
  localparam int NUM_W = $clog2(RATE_NUM + 1);
  localparam int DC_W  = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] NUM_INIT = NUM_W'(RATE_NUM);

  // configuration
  logic [CFG_W-1:0] delay_r, limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= MIN_MAX_DELAY_RST;
      limit_r <= RESTART_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_MAX_DELAY: delay_r <= cfg_wdata;
        CFG_RESTART_LIMIT: limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // delta stage
  logic [TS_W-1:0]   ts_r, prev_r;
  logic [RATE_W-1:0] delta_r;
  logic [TS_W-1:0]   diff;

  assign diff = ts_r - prev_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ts_r <= in_data[TS_W-1:0];
    end
    if (cmd.delta) begin
      if (ts_r < prev_r) begin
        delta_r <= '0;
      end else if (|diff[TS_W-1:RATE_W]) begin
        delta_r <= '1;
      end else begin
        delta_r <= diff[RATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.delta) begin
      prev_r <= ts_r;
    end
  end

  // ring and window sum; entries not yet written read as zero
  logic [AW-1:0]     pos_r;
  logic              filled_r;
  logic [SUM_W-1:0]  ws_r;
  logic [RATE_W-1:0] ram_rdata;
  logic [RATE_W-1:0] old_delta;
  logic              pos_wrap;

  assign old_delta = filled_r ? ram_rdata : '0;
  assign pos_wrap  = (pos_r == AW'(WINDOW_DEPTH - 1));

  wfrm_ram #(
    .WIDTH (RATE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.wsum),
    .waddr (pos_r),
    .wdata (delta_r),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      filled_r <= 1'b0;
      ws_r     <= '0;
    end else if (cmd.wsum) begin
      ws_r  <= ws_r - SUM_W'(old_delta) + SUM_W'(delta_r);
      pos_r <= pos_wrap ? '0 : pos_r + AW'(1);
      if (pos_wrap) begin
        filled_r <= 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [NUM_W-1:0] num_r, quot_r;
  logic [SUM_W-1:0] rem_r;
  logic [DC_W-1:0]  dcnt_r;
  logic [SUM_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, ws_r});
  assign status.div_last = (dcnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num_r  <= NUM_INIT;
      rem_r  <= '0;
      quot_r <= '0;
      dcnt_r <= DC_W'(NUM_W - 1);
    end else if (cmd.div_step) begin
      num_r  <= {num_r[NUM_W-2:0], 1'b0};
      rem_r  <= fits ? SUM_W'(trial - {1'b0, ws_r}) : SUM_W'(trial);
      quot_r <= {quot_r[NUM_W-2:0], fits};
      dcnt_r <= dcnt_r - DC_W'(1);
    end
  end

  // statistics
  logic [RATE_W-1:0]  rate;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_upd;
  logic [RATE_W-1:0]  low_upd, high_upd;
  logic [CNT_W:0]     next_cnt;
  logic               track, clr;

  logic [TOTAL_W-1:0] total_r;
  logic [CNT_W-1:0]   count_r;
  logic [RATE_W-1:0]  low_r, high_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_comb begin
    if (ws_r == '0 || |(quot_r >> RATE_W)) begin
      rate = '1;
    end else begin
      rate = RATE_W'(quot_r);
    end
    total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(rate);
    total_upd = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    track     = (count_r > delay_r);
    high_upd  = (track && rate > high_r) ? rate : high_r;
    low_upd   = (track && rate < low_r) ? rate : low_r;
    next_cnt  = {1'b0, count_r} + (CNT_W + 1)'(1);
    clr       = (next_cnt > {1'b0, limit_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      count_r <= '0;
      low_r   <= '1;
      high_r  <= '0;
    end else if (cmd.stats) begin
      if (clr) begin
        total_r <= '0;
        count_r <= '0;
        low_r   <= '1;
        high_r  <= '0;
      end else begin
        total_r <= total_upd;
        count_r <= next_cnt[CNT_W-1:0];
        low_r   <= low_upd;
        high_r  <= high_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stats) begin
      if (clr) begin
        out_data_r <= {{CNT_W{1'b0}}, {TOTAL_W{1'b0}}, {RATE_W{1'b0}},
                       {RATE_W{1'b1}}, rate};
      end else begin
        out_data_r <= {next_cnt[CNT_W-1:0], total_upd, high_upd, low_upd, rate};
      end
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

>>> rtl/wfrm_ctrl.sv
// ----------------------------------------------------------------------------
// wfrm_ctrl: controller of the windowed frame rate meter
// Sequences one frame through delta, window update, division and statistics,
// and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module wfrm_ctrl
  import wfrm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd.delta = 1'b1;
        state_nxt = S_WSUM;
      end
      S_WSUM: begin
        cmd.wsum  = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_STATS;
        end
      end
      S_STATS: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.stats     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> test/tb_windowed_frame_rate_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_frame_rate_meter: self-checking bench for the frame rate meter
// Streams frame timestamps into the meter while a scoreboard computes the
// windowed rate, min, max, sum and frame count for each one. It compares every
// result word field by field. Both stream sides idle at random. The register
// settings change between phases, only when the meter has drained.
// ----------------------------------------------------------------------------

module tb_windowed_frame_rate_meter;
  import wfrm_pkg::*;

  localparam int WINDOW = WFRM_DEPTH_DEF;
  localparam longint unsigned RATE_NUM = longint'(WINDOW) * 64'd256000000;
  localparam logic [31:0] RATE_ONES = 32'hFFFF_FFFF;
  localparam logic [47:0] TOTAL_TOP = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SETTLE_CYCLES = 60;

  // Opening frames: zero window, exact and saturated deltas, backward time
  localparam int OPENING_N = 22;
  localparam logic [63:0] OPENING [OPENING_N] = '{
    64'h0, 64'h0, 64'h1, 64'h2,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
    64'h0000_0000_FFFF_FFFF, 64'h0000_0001_FFFF_FFFF, 64'h0000_0001_FFFF_FFFF,
    64'h0000_0002_0000_4123, 64'h0000_0002_0000_8246, 64'h0000_0002_0000_C369,
    64'h0000_0002_0001_048C, 64'h0000_0002_0001_45AF, 64'h0000_0002_0001_86D2,
    64'h0000_0002_0001_C7F5, 64'h0000_0002_0002_0918, 64'h0000_0002_0002_4A3B,
    64'h0000_0002_0002_8B5E, 64'h0000_0002_0002_CC81, 64'h0000_0002_0002_CC82,
    64'h8000_0000_0000_0000
  };

  // Layout of one result word, highest field first
  typedef struct packed {
    logic [15:0] frames_counted;
    logic [47:0] rate_sum;
    logic [31:0] max_rate;
    logic [31:0] min_rate;
    logic [31:0] frame_rate;
  } frame_stats_t;

  class rate_scoreboard;
    logic [CFG_W-1:0] track_delay;
    logic [CFG_W-1:0] clear_limit;
    logic [63:0]      last_ts;
    logic [31:0]      deltas [WINDOW];
    int unsigned      slot;
    logic [35:0]      window_total;
    logic [47:0]      rate_total;
    logic [15:0]      frame_count;
    logic [31:0]      lowest;
    logic [31:0]      highest;
    frame_stats_t     pending [$];
    int unsigned      errors;
    int unsigned      accepted;
    int unsigned      compared;

    function new();
      track_delay  = MIN_MAX_DELAY_RST;
      clear_limit  = RESTART_LIMIT_RST;
      last_ts      = '0;
      foreach (deltas[i]) deltas[i] = '0;
      slot         = 0;
      window_total = '0;
      errors       = 0;
      accepted     = 0;
      compared     = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      rate_total  = '0;
      frame_count = '0;
      lowest      = RATE_ONES;
      highest     = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_MIN_MAX_DELAY: track_delay = val;
        CFG_RESTART_LIMIT: clear_limit = val;
        default: ;
      endcase
    endfunction

    function void note_frame(logic [63:0] ts);
      logic [63:0]     diff;
      logic [31:0]     delta;
      longint unsigned quot;
      logic [31:0]     rate;
      logic [48:0]     grown;
      logic [16:0]     next_count;
      frame_stats_t    want;
      diff  = (ts >= last_ts) ? ts - last_ts : 64'd0;
      delta = (diff > 64'(RATE_ONES)) ? RATE_ONES : diff[31:0];
      last_ts = ts;

      window_total = window_total - 36'(deltas[slot]) + 36'(delta);
      deltas[slot] = delta;
      slot = (slot + 1) % WINDOW;

      if (window_total == '0) begin
        rate = RATE_ONES;
      end else begin
        quot = RATE_NUM / 64'(window_total);
        rate = (quot > 64'(RATE_ONES)) ? RATE_ONES : quot[31:0];
      end

      grown = 49'(rate_total) + 49'(rate);
      rate_total = (grown > 49'(TOTAL_TOP)) ? TOTAL_TOP : grown[47:0];

      if (frame_count > track_delay) begin
        if (rate > highest) highest = rate;
        if (rate < lowest) lowest = rate;
      end

      next_count = 17'(frame_count) + 17'd1;
      if (next_count > 17'(clear_limit)) clear_stats();
      else frame_count = next_count[15:0];

      want.frame_rate     = rate;
      want.min_rate       = lowest;
      want.max_rate       = highest;
      want.rate_sum       = rate_total;
      want.frames_counted = frame_count;
      pending.push_back(want);
      accepted++;
    endfunction

    function void field_diff(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        if (errors < MAX_REPORTS)
          $display("[%0t] result %0d: %s expected %h, got %h",
                   $time, compared, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(frame_stats_t got);
      frame_stats_t want;
      if (pending.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("[%0t] result word with no frame pending: %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      field_diff("frame_rate", 64'(want.frame_rate), 64'(got.frame_rate));
      field_diff("min_rate", 64'(want.min_rate), 64'(got.min_rate));
      field_diff("max_rate", 64'(want.max_rate), 64'(got.max_rate));
      field_diff("rate_sum", 64'(want.rate_sum), 64'(got.rate_sum));
      field_diff("frames_counted", 64'(want.frames_counted), 64'(got.frames_counted));
      compared++;
    endfunction

    function bit drained();
      return pending.size() == 0;
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;    // [63:0] timestamp_us
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [31:0] frame_rate, [63:32] min_rate, [95:64] max_rate,
  // [143:96] rate_sum, [159:144] frames_counted
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  rate_scoreboard sb = new();
  bit             calm = 1'b0;
  int unsigned    stall_left = 0;
  int unsigned    settings_used = 0;
  logic [63:0]    now_us = '0;

  windowed_frame_rate_meter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then one that spans a whole frame or more
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(40, 120);
  endfunction

  // Mostly steady frame periods, plus bursts, backward steps and wild jumps
  function automatic logic [63:0] next_timestamp();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 68) now_us = now_us + 64'($urandom_range(200, 70000));
    else if (r < 76) now_us = now_us + 64'($urandom_range(0, 3));
    else if (r < 82) now_us = now_us - 64'($urandom_range(1, 200000));
    else if (r < 88) now_us = now_us + (64'({$urandom, $urandom}) >> $urandom_range(16, 40));
    else if (r < 94) now_us = {$urandom, $urandom};
    return now_us;
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(frame_stats_t'(out_tdata));
      if (in_tvalid && in_tready) sb.note_frame(in_tdata);
    end
  end

  // Hold valid low for the gap, then present the word until it is taken
  task automatic send_frame(input logic [63:0] ts, input int unsigned gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ts;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (!sb.drained()) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_MAX_DELAY;
    cfg_wdata <= delay;
    @(posedge clk);
    cfg_index <= CFG_RESTART_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_MIN_MAX_DELAY, delay);
    sb.set_reg(CFG_RESTART_LIMIT, limit);
    settings_used++;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] limit,
                           input int unsigned frames, input bit quiet);
    drain();
    write_regs(delay, limit);
    calm = quiet;
    repeat (frames) send_frame(next_timestamp(), pick_gap());
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values first
    settings_used = 1;
    for (int i = 0; i < OPENING_N; i++) send_frame(OPENING[i], pick_gap());
    now_us = OPENING[OPENING_N-1];

    run_phase(16'd0, 16'd1, 40, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 200, 1'b0);
    run_phase(16'd3, 16'd0, 30, 1'b0);
    run_phase(16'd0, 16'hFFFF, 150, 1'b1);
    for (int p = 0; p < 5; p++)
      run_phase(16'($urandom_range(0, 40)), 16'($urandom_range(1, 200)), 120, 1'b0);
    drain();

    $display("Covered %0d frames under %0d register settings, %0d result words compared.",
             sb.accepted, settings_used, sb.compared);
    if (sb.errors == 0 && sb.drained())
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
